FILE: design/masked_mean_color_assert.svh
// assertion macros shared by the masked mean color rtl
// no dependencies; take in with `include after the module header
`ifndef MASKED_MEAN_COLOR_ASSERT_SVH
`define MASKED_MEAN_COLOR_ASSERT_SVH

// property that must hold at every edge outside reset
`define MMC_ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("masked_mean_color: check failed");

// same-cycle implication
`define MMC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("masked_mean_color: check failed");

// next-cycle implication
`define MMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("masked_mean_color: check failed");

`endif

FILE: design/mmc_pkg.sv
// shared types and constants of the masked mean color block
// no dependencies
package mmc_pkg;

  localparam int unsigned PIX_W              = 8;
  localparam int unsigned NUM_CH             = 3;
  localparam int unsigned COUNT_OUT_W        = 17;
  localparam int unsigned QUOT_W             = 8;
  localparam int unsigned STEP_W             = $clog2(QUOT_W);
  localparam int unsigned MAX_PIXELS_DEFAULT = 65536;

  localparam logic [PIX_W-1:0] WHITE_LIMIT_RESET = 8'd250;

  // apb register map: one 32-bit register per word
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned REG_INDEX_LSB = 2;

  typedef enum logic [0:0] {
    REG_WHITE_LIMIT = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

FILE: design/mmc_pixel_if.sv
// pixel beat channel: valid/ready handshake with one bgr pixel
// depends on mmc_pkg
interface mmc_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [mmc_pkg::PIX_W-1:0] pixel_blue;
  logic [mmc_pkg::PIX_W-1:0] pixel_green;
  logic [mmc_pkg::PIX_W-1:0] pixel_red;
  logic                     last_pixel;

  modport source (output valid, pixel_blue, pixel_green, pixel_red, last_pixel,
                  input ready);
  modport sink (input valid, pixel_blue, pixel_green, pixel_red, last_pixel,
                output ready);
endinterface

FILE: design/mmc_mean_if.sv
// result beat channel: per-object means, count and overflow flag
// depends on mmc_pkg
interface mmc_mean_if;
  logic                           valid;
  logic                           ready;
  logic [mmc_pkg::PIX_W-1:0]       mean_blue;
  logic [mmc_pkg::PIX_W-1:0]       mean_green;
  logic [mmc_pkg::PIX_W-1:0]       mean_red;
  logic [mmc_pkg::COUNT_OUT_W-1:0] counted_pixels;
  logic                           too_long;

  modport source (output valid, mean_blue, mean_green, mean_red, counted_pixels,
                  too_long, input ready);
  modport sink (input valid, mean_blue, mean_green, mean_red, counted_pixels,
                too_long, output ready);
endinterface

FILE: design/mmc_regs.sv
// apb configuration register file (white limit)
// depends on mmc_pkg
module mmc_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mmc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mmc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mmc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [mmc_pkg::PIX_W-1:0]         white_limit
);

  logic [mmc_pkg::APB_ADDR_W-mmc_pkg::REG_INDEX_LSB-1:0] reg_idx;
  logic                                                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mmc_pkg::APB_ADDR_W-1:mmc_pkg::REG_INDEX_LSB];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_limit <= mmc_pkg::WHITE_LIMIT_RESET;
    end else if (wr_en && (reg_idx == mmc_pkg::REG_WHITE_LIMIT)) begin
      white_limit <= pwdata[mmc_pkg::PIX_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      mmc_pkg::REG_WHITE_LIMIT: prdata = mmc_pkg::APB_DATA_W'(white_limit);
      default:                  prdata = '0;
    endcase
  end

endmodule

FILE: design/mmc_ctrl.sv
// controller: accumulate / divide / hand-off sequencing
// depends on mmc_pkg; drives mmc_datapath through dp_cmd_t
module mmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output mmc_pkg::dp_cmd_t    cmd,
  input  mmc_pkg::dp_status_t status
);

  localparam logic [mmc_pkg::STEP_W-1:0] LAST_STEP = mmc_pkg::STEP_W'(mmc_pkg::QUOT_W - 1);

  mmc_pkg::state_t             state, state_next;
  logic [mmc_pkg::STEP_W-1:0]  step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmc_pkg::ST_ACCUM;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      mmc_pkg::ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_next = mmc_pkg::ST_DIVIDE;
          step_next  = '0;
        end
      end
      mmc_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_next    = step + mmc_pkg::STEP_W'(1);
        if (step == LAST_STEP) begin
          state_next = mmc_pkg::ST_FINISH;
        end
      end
      mmc_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = mmc_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_next = mmc_pkg::ST_ACCUM;
      end
    endcase
  end

endmodule

FILE: design/mmc_datapath.sv
// datapath: channel sums, pixel count, shared restoring divider, output register
// depends on mmc_pkg and masked_mean_color_assert.svh
module mmc_datapath #(
  parameter int unsigned MAX_PIXELS = mmc_pkg::MAX_PIXELS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mmc_pkg::dp_cmd_t                  cmd,
  output mmc_pkg::dp_status_t               status,
  input  logic [mmc_pkg::PIX_W-1:0]         white_limit,
  input  logic [mmc_pkg::PIX_W-1:0]         pixel_blue,
  input  logic [mmc_pkg::PIX_W-1:0]         pixel_green,
  input  logic [mmc_pkg::PIX_W-1:0]         pixel_red,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [mmc_pkg::PIX_W-1:0]         mean_blue,
  output logic [mmc_pkg::PIX_W-1:0]         mean_green,
  output logic [mmc_pkg::PIX_W-1:0]         mean_red,
  output logic [mmc_pkg::COUNT_OUT_W-1:0]   counted_pixels,
  output logic                              too_long
);

  `include "masked_mean_color_assert.svh"

  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SUM_W = CNT_W + mmc_pkg::PIX_W;
  localparam int unsigned DIV_W = CNT_W + mmc_pkg::QUOT_W - 1;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(MAX_PIXELS);

  logic [mmc_pkg::PIX_W-1:0]                 px   [mmc_pkg::NUM_CH];
  logic [SUM_W-1:0]                          acc  [mmc_pkg::NUM_CH];
  logic [SUM_W-1:0]                          diff [mmc_pkg::NUM_CH];
  logic [mmc_pkg::QUOT_W-1:0]                quot [mmc_pkg::NUM_CH];
  logic [mmc_pkg::NUM_CH-1:0]                fits;
  logic [CNT_W-1:0]                          tally, tally_next;
  logic [CNT_W+mmc_pkg::COUNT_OUT_W-1:0]     tally_wide;
  logic [DIV_W-1:0]                          divsr;
  logic [SUM_W-1:0]                          divsr_ext;
  logic                                      in_object, overflowed;
  logic                                      near_white, take_px, at_limit, grow;
  logic                                      rem_ok;

  always_comb begin
    px[0] = pixel_blue;
    px[1] = pixel_green;
    px[2] = pixel_red;
  end

  // first pixel of an object is always taken
  assign near_white = (pixel_blue > white_limit) && (pixel_green > white_limit)
                      && (pixel_red > white_limit);
  assign take_px    = !in_object || !near_white;
  assign at_limit   = (tally == COUNT_LIMIT);
  assign grow       = cmd.accept && take_px && !at_limit;
  assign tally_next = grow ? tally + CNT_W'(1) : tally;
  assign tally_wide = {{mmc_pkg::COUNT_OUT_W{1'b0}}, tally};
  assign divsr_ext  = {1'b0, divsr};

  // one restoring step per channel, all sharing the shifted divisor
  always_comb begin
    for (int c = 0; c < mmc_pkg::NUM_CH; c++) begin
      fits[c] = (acc[c] >= divsr_ext);
      diff[c] = acc[c] - divsr_ext;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tally      <= '0;
      in_object  <= 1'b0;
      overflowed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        tally      <= '0;
        in_object  <= 1'b0;
        overflowed <= 1'b0;
      end else if (cmd.accept) begin
        in_object <= 1'b1;
        tally     <= tally_next;
        if (take_px && at_limit) begin
          overflowed <= 1'b1;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sums double as division remainders
  always_ff @(posedge clk) begin
    for (int c = 0; c < mmc_pkg::NUM_CH; c++) begin
      if (rst || cmd.finish) begin
        acc[c] <= '0;
      end else if (grow) begin
        acc[c] <= acc[c] + SUM_W'(px[c]);
      end else if (cmd.div_step && fits[c]) begin
        acc[c] <= diff[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      divsr <= {tally_next, {(mmc_pkg::QUOT_W-1){1'b0}}};
    end else if (cmd.div_step) begin
      divsr <= divsr >> 1;
    end
    for (int c = 0; c < mmc_pkg::NUM_CH; c++) begin
      if (cmd.div_step) begin
        quot[c] <= {quot[c][mmc_pkg::QUOT_W-2:0], fits[c]};
      end
    end
    if (cmd.finish) begin
      mean_blue      <= quot[0];
      mean_green     <= quot[1];
      mean_red       <= quot[2];
      counted_pixels <= tally_wide[mmc_pkg::COUNT_OUT_W-1:0];
      too_long       <= overflowed;
    end
  end

  // every remainder ends below the divisor
  assign rem_ok = (acc[0] < SUM_W'(tally)) && (acc[1] < SUM_W'(tally))
                  && (acc[2] < SUM_W'(tally));

  `MMC_ASSERT_ALWAYS(a_tally_bound, clk, rst, tally <= COUNT_LIMIT)
  `MMC_ASSERT_IMPL(a_div_nonzero, clk, rst, cmd.div_step, tally != '0)
  `MMC_ASSERT_IMPL(a_rem_below_count, clk, rst, cmd.finish, rem_ok)
  `MMC_ASSERT_NEXT(a_clear_after_finish, clk, rst, cmd.finish, (tally == '0) && !in_object && out_valid)

endmodule

FILE: design/masked_mean_color.sv
// masked_mean_color top level: mean bgr color of one object region
// depends on mmc_pkg, mmc_pixel_if, mmc_mean_if, mmc_regs, mmc_ctrl, mmc_datapath
//
// usage
//   pixel_in : one bgr pixel per beat, last_pixel marks the final pixel of an object
//   mean_out : one beat per object with the truncated channel means, the count of
//              pixels taken into the means and a too_long flag
//   apb port : single register white_limit at byte address 0 (reset 250); a pixel
//              with all three channels above it is skipped, except the first of
//              an object
// throughput and stalls
//   pixels are taken one per cycle while an object streams in
//   after the last pixel the input stalls while the shared restoring divider
//   runs (one quotient bit for all three channels per cycle) and until the
//   result is loaded into the output register
// reset
//   sync active-high rst clears sums, count, flags and the output valid bit,
//   and sets white_limit back to 250
// back-pressure
//   the result sits in an output register; the next object streams in while
//   it waits, and only its hand-off waits for mean_out to drain
module masked_mean_color #(
  parameter int unsigned MAX_PIXELS = mmc_pkg::MAX_PIXELS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  mmc_pixel_if.sink                      pixel_in,
  mmc_mean_if.source                     mean_out,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mmc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mmc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mmc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  // configuration
  logic [mmc_pkg::PIX_W-1:0] white_limit;

  // controller <-> datapath
  mmc_pkg::dp_cmd_t    dp_cmd;
  mmc_pkg::dp_status_t dp_status;

  mmc_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .white_limit (white_limit)
  );

  // sequencing: accumulate pixels, run the divider, hand off the result
  mmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel_in.valid),
    .in_last  (pixel_in.last_pixel),
    .in_ready (pixel_in.ready),
    .cmd      (dp_cmd),
    .status   (dp_status)
  );

  // sums, count, divider and output register
  mmc_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (dp_cmd),
    .status         (dp_status),
    .white_limit    (white_limit),
    .pixel_blue     (pixel_in.pixel_blue),
    .pixel_green    (pixel_in.pixel_green),
    .pixel_red      (pixel_in.pixel_red),
    .out_ready      (mean_out.ready),
    .out_valid      (mean_out.valid),
    .mean_blue      (mean_out.mean_blue),
    .mean_green     (mean_out.mean_green),
    .mean_red       (mean_out.mean_red),
    .counted_pixels (mean_out.counted_pixels),
    .too_long       (mean_out.too_long)
  );

endmodule
